@@ src/assert_macros.svh @@
// assertion macros used by pdh_core of the peak detector
// no dependencies; the checks are left out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication check, disabled while reset is low
`define PDH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pdh assertion failed");

// condition that must never be true outside reset
`define PDH_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pdh forbidden condition seen");

`else

`define PDH_ASSERT(label, clk, rst_n, prop)
`define PDH_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ src/pdh_pkg.sv @@
// types and constants of the peak detector
// no dependencies
package pdh_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int VAL_W       = SAMPLE_BITS + 1;   // after negation
    localparam int TOL_W       = 17;
    localparam int TOL_FRAC    = 16;
    localparam int PROD_W      = TOL_W + VAL_W;
    localparam int CFG_DATA_W  = (SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TOL_W-1:0] TOL_ONE   = TOL_W'(1 << TOL_FRAC);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(6554);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [VAL_W-1:0]       t_val;

    // most negative value of the widened sample
    localparam t_val PEAK_RESET = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_RISE = 2'd0,
        MODE_FALL = 2'd1,
        MODE_MAX  = 2'd2,
        MODE_MIN  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER = 2'd0,
        CFG_RELOAD  = 2'd1,
        CFG_TOL     = 2'd2,
        CFG_MODE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_sample           trigger;
        t_sample           reload;
        logic [TOL_W-1:0]  tol;
        t_mode             mode;
    } t_cfg;

endpackage

@@ src/pdh_ifs.sv @@
// valid/ready channel interfaces of the peak detector
// depends on pdh_pkg
interface pdh_sample_if import pdh_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pdh_detect_if import pdh_pkg::*; ();
    logic valid;
    logic ready;
    logic detected;
    modport source (output valid, output detected, input ready);
    modport sink   (input valid, input detected, output ready);
endinterface

interface pdh_cfg_if import pdh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/pdh_cfg_regs.sv @@
// configuration registers of the peak detector
// depends on pdh_pkg and pdh_cfg_if
module pdh_cfg_regs import pdh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pdh_cfg_if.sink  i_cfg,
    output t_cfg     o_cfg,
    output logic     o_clear
);

    t_cfg r_cfg;
    logic [TOL_W-1:0] n_tol;

    assign i_cfg.ready = 1'b1;

    // tolerance above one saturates to one
    always_comb begin
        n_tol = i_cfg.data[TOL_W-1:0];
        if (n_tol > TOL_ONE) begin
            n_tol = TOL_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger <= '0;
            r_cfg.reload  <= '0;
            r_cfg.tol     <= TOL_RESET;
            r_cfg.mode    <= MODE_RISE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TRIGGER: r_cfg.trigger <= t_sample'(i_cfg.data[SAMPLE_BITS-1:0]);
                CFG_RELOAD:  r_cfg.reload  <= t_sample'(i_cfg.data[SAMPLE_BITS-1:0]);
                CFG_TOL:     r_cfg.tol     <= n_tol;
                CFG_MODE:    r_cfg.mode    <= t_mode'(i_cfg.data[1:0]);
                default:     r_cfg.mode    <= r_cfg.mode;
            endcase
        end
    end

    assign o_cfg   = r_cfg;
    // every index names a register, so every write restarts the detector
    assign o_clear = i_cfg.valid;

endmodule

@@ src/pdh_core.sv @@
// detector state and per-item evaluation of the peak detector
// depends on pdh_pkg and assert_macros.svh
`include "assert_macros.svh"

module pdh_core import pdh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_clear,
    input  logic    i_advance,
    input  t_sample i_sample,
    output logic    o_detected
);

    logic r_first, r_armed, r_above, r_last;
    t_val r_peak;
    logic n_first, n_armed, n_above, n_last;
    t_val n_peak;

    logic inverted, cross_mode, high, crossing, fell, share;
    t_val v_raw, t_raw, r_raw, v, t, r_eff;
    logic signed [VAL_W:0] d_pt, d_pv;
    logic [VAL_W-1:0]      m_pt, m_pv;
    logic [PROD_W-1:0]     span, drop;

    always_comb begin
        inverted   = (i_cfg.mode == MODE_FALL) || (i_cfg.mode == MODE_MIN);
        cross_mode = (i_cfg.mode == MODE_RISE) || (i_cfg.mode == MODE_FALL);
        v_raw = t_val'(i_sample);
        t_raw = t_val'(i_cfg.trigger);
        r_raw = t_val'(i_cfg.reload);
        v = inverted ? -v_raw : v_raw;
        t = inverted ? -t_raw : t_raw;
        r_eff = inverted ? -r_raw : r_raw;
        if (r_eff > t) begin
            r_eff = t;
        end
        high = (v >= t);

        // differences are not negative wherever the product is used
        d_pt = {r_peak[VAL_W-1], r_peak} - {t[VAL_W-1], t};
        d_pv = {r_peak[VAL_W-1], r_peak} - {v[VAL_W-1], v};
        m_pt = d_pt[VAL_W-1:0];
        m_pv = d_pv[VAL_W-1:0];
        span = PROD_W'(i_cfg.tol) * PROD_W'(m_pt);
        drop = PROD_W'({m_pv, {TOL_FRAC{1'b0}}});
        share = (r_peak > t) && (drop >= span);

        n_first = r_first;
        n_armed = r_armed;
        n_above = r_above;
        n_peak  = r_peak;
        n_last  = r_last;
        crossing = 1'b0;
        fell     = 1'b0;

        if (r_first) begin
            // first item only primes the arm flag
            n_armed = !high;
            n_first = 1'b0;
        end else begin
            crossing = high && r_armed;
            if (crossing) begin
                n_armed = 1'b0;
                n_above = 1'b1;
            end else if (v <= r_eff) begin
                n_armed = 1'b1;
            end
            if (n_above) begin
                if (v > r_peak) begin
                    n_peak = v;
                end else if (share || !high) begin
                    fell    = 1'b1;
                    n_above = 1'b0;
                    n_peak  = PEAK_RESET;
                end
            end
            n_last = cross_mode ? crossing : fell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_first <= 1'b1;
            r_armed <= 1'b1;
            r_above <= 1'b0;
            r_peak  <= PEAK_RESET;
            r_last  <= 1'b0;
        end else if (i_advance) begin
            r_first <= n_first;
            r_armed <= n_armed;
            r_above <= n_above;
            r_peak  <= n_peak;
            r_last  <= n_last;
        end
    end

    assign o_detected = n_last;

    `PDH_ASSERT(a_peak_idle, i_clk, i_rst_n, !r_above |-> (r_peak == PEAK_RESET))
    `PDH_NEVER(a_first_above, i_clk, i_rst_n, r_first && r_above)
    `PDH_ASSERT(a_cross_disarms, i_clk, i_rst_n,
                (i_advance && !i_clear && crossing) |=> (!r_armed && r_above))
    `PDH_ASSERT(a_cross_stays, i_clk, i_rst_n,
                (!i_advance && !i_clear) |=> $stable(r_peak) && $stable(r_armed))

endmodule

@@ src/peak_detector_hysteresis.sv @@
// top level of the threshold peak detector with hysteresis
// depends on pdh_pkg, pdh_ifs, pdh_cfg_regs and pdh_core
//
//  port     | dir | moves                        | handshake
//  ---------+-----+------------------------------+-------------
//  i_smp    | in  | one signed sample per item   | valid/ready
//  o_det    | out | one detection bit per item   | valid/ready
//  i_cfg    | in  | register index and data      | valid/ready
//
// every item passes an input register and then a result register; one item per
// cycle is sustained while results are taken, since the state update and
// tolerance multiply in pdh_core are combinational before the state registers
// a full result register that is not taken holds the input register, which in
// turn drops i_smp.ready; both fill and drain in the same cycle
// reset (i_rst_n, synchronous, active low) restores the register defaults and
// clears the detector state; a configuration write also clears the state
module peak_detector_hysteresis import pdh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdh_sample_if.sink    i_smp,
    pdh_detect_if.source  o_det,
    pdh_cfg_if.sink       i_cfg
);

    // input register
    logic    r_in_valid;
    t_sample r_in_sample;
    // result register
    logic    r_out_valid;
    logic    r_out_detected;

    logic out_free, advance, detected;
    t_cfg cfg;
    logic clear;

    // result register can load when empty or being drained
    assign out_free    = !r_out_valid || o_det.ready;
    assign advance     = r_in_valid && out_free;
    assign i_smp.ready = !r_in_valid || advance;

    pdh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg),
        .o_clear (clear)
    );

    pdh_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_clear    (clear),
        .i_advance  (advance),
        .i_sample   (r_in_sample),
        .o_detected (detected)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_smp.ready && i_smp.valid) begin
            r_in_sample <= i_smp.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_detected <= detected;
        end
    end

    assign o_det.valid    = r_out_valid;
    assign o_det.detected = r_out_detected;

endmodule
